FILE: rtl/ordered_array_list_top_macros.svh
// Assertion macros shared by the checker of the ordered array list.
`ifndef ORDERED_ARRAY_LIST_TOP_MACROS_SVH
`define ORDERED_ARRAY_LIST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst
`define OAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst
`define OAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/oal_pkg.sv
// Shared types, codes and field layout of the ordered array list.
package oal_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // Input item layout
  localparam int CMD_LSB   = 0;
  localparam int POS_LSB   = CMD_LSB + CMD_W;
  localparam int VAL_LSB   = POS_LSB + POS_W;
  localparam int S_USED_W  = VAL_LSB + VAL_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  // Result item layout
  localparam int VOUT_LSB   = 0;
  localparam int FPOS_LSB   = VOUT_LSB + VAL_W;
  localparam int STATUS_LSB = FPOS_LSB + POS_W;
  localparam int COUNT_LSB  = STATUS_LSB + STATUS_W;
  localparam int EMPTY_BIT  = COUNT_LSB + COUNT_W;
  localparam int M_USED_W   = EMPTY_BIT + 1;
  localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_GET    = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Operation broadcast to every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_INSERT,
    OP_DELETE,
    OP_LOCATE,
    OP_READ
  } cell_op_t;

endpackage

FILE: rtl/ordered_array_list_top.sv
// Top level of the ordered array list: command decode, cell row and result stage.
// Usage
//   Input items arrive on s_tvalid/s_tready/s_tdata and carry a command
//   (clear, insert, delete, locate, get), a 1-based position and a value.
//   Every item yields exactly one result item on m_tvalid/m_tready/m_tdata
//   with the removed or read value, the found position, a status code, the
//   length after the command and an empty flag.
//   The list sits in a row of cells, one entry per cell; insert and delete
//   move every later entry one cell in the same cycle, and locate compares
//   all cells at once.
//   The command acts on the row in its accept cycle; its match flags, taps,
//   status and length are registered in the match/tap stage and then in the
//   single result register on m_tvalid. Throughput: one item a cycle unless m_tready stalls.
//   Reset (rst, synchronous) empties the list and drops any pending result.
//   When the receiver stalls, the result holds and one more item is taken
//   into the match/tap stage; s_tready then falls until the result moves.
module ordered_array_list_top #(
  parameter int DEPTH      = oal_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = oal_pkg::ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // cmd[2:0], pos[9:3], value[41:10], zero pad
  input  logic [oal_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // value_out[31:0], found_pos[38:32], status[41:39], count[48:42],
  // is_empty[49], zero pad
  output logic [oal_pkg::M_TDATA_W-1:0] m_tdata
);
  import oal_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Handshake and control
  logic take;
  logic load_out;
  logic pend;

  // Input fields
  cmd_t                         in_cmd;
  logic [POS_W-1:0]             in_pos;
  logic signed [VAL_W-1:0]      in_value;
  logic signed [ELEM_WIDTH-1:0] elem;
  logic [PW-1:0]                pos_w;
  logic [PW-1:0]                fill_w;

  // Length and decode
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  cell_op_t      op;
  status_t       status;

  // Resolve stage registers
  cmd_t          r_cmd;
  status_t       r_status;
  logic [CW-1:0] r_count;

  // Cell row
  logic [ELEM_WIDTH-1:0] word    [DEPTH];
  logic [ELEM_WIDTH-1:0] left_w  [DEPTH];
  logic [ELEM_WIDTH-1:0] right_w [DEPTH];
  logic [ELEM_WIDTH-1:0] tap     [DEPTH];
  logic [DEPTH-1:0]      hit;

  // Resolve logic
  logic [DEPTH-1:0]             first_hit;
  logic                         any_hit;
  logic [IW-1:0]                hit_idx;
  logic signed [ELEM_WIDTH-1:0] tap_or;
  logic [PW-1:0]                fpos_w;
  logic [PW-1:0]                count_w;
  status_t                      status_out;
  logic [VAL_W-1:0]             vout;

  assign load_out = pend && (!m_tvalid || m_tready);
  assign s_tready = !pend || load_out;
  assign take     = s_tvalid && s_tready;

  assign in_cmd   = cmd_t'(s_tdata[CMD_LSB +: CMD_W]);
  assign in_pos   = s_tdata[POS_LSB +: POS_W];
  assign in_value = s_tdata[VAL_LSB +: VAL_W];
  assign elem     = ELEM_WIDTH'(in_value);
  assign pos_w    = PW'(in_pos);
  assign fill_w   = PW'(fill);

  // Check the command against the length and pick the row operation
  always_comb begin
    op        = OP_HOLD;
    status    = ST_OK;
    fill_next = fill;
    if (take) begin
      case (in_cmd)
        CMD_CLEAR: begin
          op        = OP_CLEAR;
          fill_next = '0;
        end
        CMD_INSERT: begin
          if (pos_w == '0 || pos_w > fill_w + PW'(1)) begin
            status = ST_BAD_POS;
          end else if (fill_w == PW'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            op        = OP_INSERT;
            fill_next = fill + CW'(1);
          end
        end
        CMD_DELETE: begin
          if (fill == '0) begin
            status = ST_EMPTY;
          end else if (pos_w == '0 || pos_w > fill_w) begin
            status = ST_BAD_POS;
          end else begin
            op        = OP_DELETE;
            fill_next = fill - CW'(1);
          end
        end
        CMD_LOCATE: begin
          op = OP_LOCATE;
        end
        CMD_GET: begin
          if (pos_w == '0 || pos_w > fill_w) begin
            status = ST_BAD_POS;
          end else begin
            op = OP_READ;
          end
        end
        default: begin
          op = OP_HOLD;
        end
      endcase
    end
  end

  // Hold the length
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Track the item waiting in the match/tap stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (take) begin
      pend <= 1'b1;
    end else if (load_out) begin
      pend <= 1'b0;
    end
  end

  // Carry command, status and length to the resolve stage
  always_ff @(posedge clk) begin
    if (take) begin
      r_cmd    <= in_cmd;
      r_status <= status;
      r_count  <= fill_next;
    end
  end

  // Build the row, each cell wired to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_inner_l
      assign left_w[i] = word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w[i] = '0;
    end else begin : g_inner_r
      assign right_w[i] = word[i+1];
    end

    oal_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .PW         (PW),
      .IDX        (i)
    ) u_cell (
      .clk   (clk),
      .take  (take),
      .op    (op),
      .pos   (pos_w),
      .fill  (fill_w),
      .elem  (elem),
      .left  (left_w[i]),
      .right (right_w[i]),
      .word  (word[i]),
      .hit   (hit[i]),
      .tap   (tap[i])
    );
  end

  // Isolate the lowest match and encode its index
  assign first_hit = hit & (~hit + DEPTH'(1));
  assign any_hit   = |hit;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // Merge the taps; at most one cell drives a non-zero word
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | tap[i];
    end
  end

  assign fpos_w     = any_hit ? (PW'(hit_idx) + PW'(1)) : '0;
  assign count_w    = PW'(r_count);
  assign status_out = (r_cmd == CMD_LOCATE) ? (any_hit ? ST_OK : ST_NOT_FOUND) : r_status;
  assign vout       = VAL_W'(tap_or);

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {(M_TDATA_W - M_USED_W)'(0),
                  (r_count == '0),
                  count_w[COUNT_W-1:0],
                  status_out,
                  fpos_w[POS_W-1:0],
                  vout};
    end
  end

endmodule

FILE: rtl/oal_cell.sv
// One storage cell of the list row: holds one entry, shifts, compares and taps.
module oal_cell #(
  parameter int ELEM_WIDTH = oal_pkg::ELEM_WIDTH_DEF,
  parameter int PW         = 8,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  take,
  input  oal_pkg::cell_op_t     op,
  input  logic [PW-1:0]         pos,
  input  logic [PW-1:0]         fill,
  input  logic [ELEM_WIDTH-1:0] elem,
  input  logic [ELEM_WIDTH-1:0] left,
  input  logic [ELEM_WIDTH-1:0] right,
  output logic [ELEM_WIDTH-1:0] word,
  output logic                  hit,
  output logic [ELEM_WIDTH-1:0] tap
);
  import oal_pkg::*;

  localparam logic [PW-1:0] SLOT = PW'(IDX + 1);

  logic                  at_pos;
  logic                  above;
  logic                  live;
  logic [ELEM_WIDTH-1:0] word_next;

  assign at_pos = (pos == SLOT);
  assign above  = (SLOT > pos);
  assign live   = (SLOT <= fill);

  // Pick the entry for the next cycle: own, neighbour's or the new one
  always_comb begin
    case (op)
      OP_CLEAR:  word_next = '0;
      OP_INSERT: word_next = at_pos ? elem : (above ? left : word);
      OP_DELETE: word_next = (at_pos || above) ? right : word;
      default:   word_next = word;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Capture the match flag and the read tap for the resolve stage
  always_ff @(posedge clk) begin
    if (take) begin
      hit <= (op == OP_LOCATE) && live && (word == elem);
      tap <= ((op == OP_DELETE || op == OP_READ) && at_pos) ? word : '0;
    end
  end

endmodule

FILE: rtl/oal_checker.sv
// Port-level checker of the ordered array list and its bind to the top level.
`include "ordered_array_list_top_macros.svh"

module oal_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [oal_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [oal_pkg::M_TDATA_W-1:0] m_tdata
);
  import oal_pkg::*;

  logic [VAL_W-1:0]    c_vout;
  logic [POS_W-1:0]    c_fpos;
  logic [STATUS_W-1:0] c_status;
  logic [COUNT_W-1:0]  c_count;
  logic                c_empty;

  assign c_vout    = m_tdata[VOUT_LSB +: VAL_W];
  assign c_fpos    = m_tdata[FPOS_LSB +: POS_W];
  assign c_status  = m_tdata[STATUS_LSB +: STATUS_W];
  assign c_count   = m_tdata[COUNT_LSB +: COUNT_W];
  assign c_empty   = m_tdata[EMPTY_BIT];

  // A stalled result keeps its item
  `OAL_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

  // With no result waiting the input side is always open
  `OAL_ASSERT_IMP(a_ready_open, !m_tvalid, s_tready, "input blocked with no result pending")

  // The empty flag follows the length
  `OAL_ASSERT_IMP(a_empty_flag, m_tvalid, c_empty == (c_count == '0), "empty flag disagrees with count")

  // A found position or a returned word only comes with an ok status
  `OAL_ASSERT_IMP(a_found_ok, m_tvalid && (c_fpos != '0), c_status == ST_OK, "match reported with error status")
  `OAL_ASSERT_IMP(a_value_ok, m_tvalid && (c_vout != '0), c_status == ST_OK, "word returned with error status")

endmodule

bind ordered_array_list_top oal_checker u_oal_checker (.*);

FILE: sim/ordered_array_list_checker.sv
// Checker for the ordered array list: predicts every result item and compares it on arrival.
`timescale 1ns / 1ps

module ordered_array_list_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [oal_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [oal_pkg::M_TDATA_W-1:0] m_tdata,
  output int                            fail_count,
  output int                            outstanding
);
  import oal_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [VAL_W-1:0]   value_out;
    logic [POS_W-1:0]   found_pos;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } list_result_t;

  // Own copy of the list contents and length
  logic [VAL_W-1:0] list_words [LIST_DEPTH];
  int               list_len;

  list_result_t pending_results [$];
  int           mismatches;
  int           pending_n;

  assign fail_count  = mismatches;
  assign outstanding = pending_n;

  // Apply one command to the list copy and work out its result item
  task automatic apply_list_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] p,
                                    input logic [VAL_W-1:0] v, output list_result_t r);
    int pi;
    int i;
    pi          = int'(p);
    r.value_out = '0;
    r.found_pos = '0;
    r.status    = ST_OK;
    case (op)
      CMD_CLEAR: begin
        for (i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
        list_len = 0;
      end
      CMD_INSERT: begin
        // position is checked before capacity
        if (pi < 1 || pi > list_len + 1) r.status = ST_BAD_POS;
        else if (list_len >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (i = list_len; i >= pi; i--) list_words[i] = list_words[i-1];
          list_words[pi-1] = v;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else if (pi < 1 || pi > list_len) r.status = ST_BAD_POS;
        else begin
          r.value_out = list_words[pi-1];
          for (i = pi; i < list_len; i++) list_words[i-1] = list_words[i];
          list_words[list_len-1] = '0;
          list_len--;
        end
      end
      CMD_LOCATE: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < list_len; i++) begin
          if (r.status == ST_NOT_FOUND && list_words[i] == v) begin
            r.found_pos = POS_W'(i + 1);
            r.status    = ST_OK;
          end
        end
      end
      CMD_GET: begin
        if (pi < 1 || pi > list_len) r.status = ST_BAD_POS;
        else r.value_out = list_words[pi-1];
      end
      default: ; // unused codes leave the list alone
    endcase
    r.count    = COUNT_W'(list_len);
    r.is_empty = (list_len == 0);
  endtask

  // Predict on every accepted input item, compare on every accepted result item
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst) begin
      for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
      list_len = 0;
      pending_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        apply_list_command(s_tdata[CMD_LSB +: CMD_W], s_tdata[POS_LSB +: POS_W],
                           s_tdata[VAL_LSB +: VAL_W], want);
        pending_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.value_out = m_tdata[VOUT_LSB +: VAL_W];
        got.found_pos = m_tdata[FPOS_LSB +: POS_W];
        got.status    = status_t'(m_tdata[STATUS_LSB +: STATUS_W]);
        got.count     = m_tdata[COUNT_LSB +: COUNT_W];
        got.is_empty  = m_tdata[EMPTY_BIT];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result item with none expected: value %h pos %0d status %0d",
                     $realtime, got.value_out, got.found_pos, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.value_out !== want.value_out || got.found_pos !== want.found_pos ||
              got.status !== want.status || got.count !== want.count ||
              got.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"%0t: result mismatch: expected value %h pos %0d status %0d ",
                        "count %0d empty %0d, got value %h pos %0d status %0d ",
                        "count %0d empty %0d"}, $realtime,
                       want.value_out, want.found_pos, want.status, want.count,
                       want.is_empty, got.value_out, got.found_pos, got.status,
                       got.count, got.is_empty);
          end
        end
      end
    end
    pending_n <= pending_results.size();
  end

  initial begin
    mismatches = 0;
    pending_n  = 0;
    list_len   = 0;
  end

endmodule

FILE: sim/ordered_array_list_top_test.sv
// Testbench top for the ordered array list: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module ordered_array_list_top_test;
  import oal_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 380;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int tx_gap_pct = 27;
  int rx_stall_pct = 64;
  int list_len = 0;  // length tracked only to aim positions

  ordered_array_list_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ordered_array_list_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_array_list_top verification failed");
      $finish;
    end
  end

  // Offer one command item, idle first at random cycle by cycle, and hold it until taken
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] p,
                              input logic [VAL_W-1:0] v);
    logic [S_TDATA_W-1:0] item;
    item                     = '0;
    item[CMD_LSB +: CMD_W]   = op;
    item[POS_LSB +: POS_W]   = p;
    item[VAL_LSB +: VAL_W]   = v;
    while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
    case (op)
      CMD_CLEAR:  list_len = 0;
      CMD_INSERT: if (p >= 1 && p <= list_len + 1 && list_len < LIST_DEPTH) list_len++;
      CMD_DELETE: if (list_len > 0 && p >= 1 && p <= list_len) list_len--;
      default: ;
    endcase
  endtask

  // Stop offering and wait for every expected result item
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mix of random words, a small set that repeats (for duplicate matches) and extremes
  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return $urandom;
    if (roll < 75) return VAL_W'($urandom_range(6)) - VAL_W'(3);
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return '0;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input int upper);
    if ($urandom_range(99) < 85) return POS_W'($urandom_range(1, (upper < 1) ? 1 : upper));
    return POS_W'($urandom_range(127));
  endfunction

  // One random command; grow_pct steers the list towards full or empty
  task automatic random_command(input int grow_pct);
    int roll;
    int pick;
    roll = $urandom_range(99);
    if (roll < 5) begin
      send_command(CMD_W'($urandom_range(7)), POS_W'($urandom_range(127)), $urandom);
    end else if (roll < 5 + grow_pct) begin
      send_command(CMD_INSERT, pick_pos(list_len + 1), pick_value());
    end else begin
      pick = $urandom_range(99);
      if (pick < 45)      send_command(CMD_DELETE, pick_pos(list_len), pick_value());
      else if (pick < 70) send_command(CMD_LOCATE, POS_W'($urandom_range(127)), pick_value());
      else if (pick < 94) send_command(CMD_GET, pick_pos(list_len), pick_value());
      else if (pick < 97)
        send_command(CMD_W'($urandom_range(CMD_GET + 1, 7)), POS_W'($urandom_range(127)),
                     $urandom);
      else send_command(CMD_CLEAR, POS_W'($urandom_range(127)), $urandom);
    end
  endtask

  // Alternate growing and shrinking bursts so the list reaches full and empty
  task automatic random_phase(input int n_items);
    int  sent;
    int  burst;
    bit  growing;
    sent    = 0;
    growing = 1'b1;
    while (sent < n_items) begin
      burst = $urandom_range(40, 110);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        random_command(growing ? 75 : 15);
        sent++;
      end
      growing = !growing;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list errors, position checks, extremes and duplicates
    send_command(CMD_GET, 7'd1, '0);
    send_command(CMD_DELETE, 7'd1, '0);
    send_command(CMD_LOCATE, 7'd0, '0);
    send_command(CMD_INSERT, 7'd0, 32'h1234_5678);
    send_command(CMD_INSERT, 7'd2, 32'h1234_5678);
    send_command(CMD_INSERT, 7'd1, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, 7'd1, 32'h8000_0000);
    send_command(CMD_INSERT, 7'd3, 32'h0000_0000);
    send_command(CMD_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 7'd2, 32'hFFFF_FFFF);
    send_command(CMD_LOCATE, 7'd127, 32'hFFFF_FFFF);
    send_command(CMD_LOCATE, 7'd0, 32'h1234_5678);
    send_command(CMD_GET, 7'd1, '0);
    send_command(CMD_GET, 7'd5, '0);
    send_command(CMD_GET, 7'd6, '0);
    send_command(CMD_GET, 7'd0, '0);
    send_command(CMD_GET, 7'd127, '0);
    send_command(CMD_DELETE, 7'd0, '0);
    send_command(CMD_DELETE, 7'd6, '0);
    send_command(CMD_DELETE, 7'd3, '0);
    send_command(CMD_DELETE, 7'd4, '0);
    for (int c = CMD_GET + 1; c < 8; c++) send_command(CMD_W'(c), 7'd127, 32'hFFFF_FFFF);
    send_command(CMD_CLEAR, 7'd127, 32'hFFFF_FFFF);
    send_command(CMD_GET, 7'd1, '0);

    // Random phases with different idling on each side
    random_phase(PHASE_ITEMS);
    drain();
    tx_gap_pct   = 64;
    rx_stall_pct = 27;
    random_phase(PHASE_ITEMS);
    drain();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    random_phase(PHASE_ITEMS);

    drain();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ordered_array_list_top verification clean");
    end else begin
      $display("ordered_array_list_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/oal_pkg.sv
rtl/oal_cell.sv
rtl/ordered_array_list_top.sv
rtl/oal_checker.sv
sim/ordered_array_list_checker.sv
sim/ordered_array_list_top_test.sv
